>>> hdl/ptp_pkg.sv
// ptp_pkg: shared types, codes and helper functions for the puck trajectory predictor.
// No dependencies; imported by every module of the block.
`default_nettype none
package ptp_pkg;

  localparam int NUM_W = 48;
  localparam int DEN_W = 16;

  typedef logic signed [NUM_W-1:0] wide_t;
  typedef logic signed [15:0]      word_t;
  typedef logic signed [10:0]      speed_t;

  // result status codes
  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_DIRECT = 2'd1;
  localparam logic [1:0] STAT_BOUNCE = 2'd2;
  localparam logic [1:0] STAT_NOISE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_DEFENSE = 3'd0;
  localparam logic [2:0] CFG_ATTACK  = 3'd1;
  localparam logic [2:0] CFG_RADIUS  = 3'd2;
  localparam logic [2:0] CFG_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_LAG     = 3'd4;

  localparam logic [11:0] RST_DEFENSE = 12'd100;
  localparam logic [11:0] RST_ATTACK  = 12'd200;
  localparam logic [7:0]  RST_RADIUS  = 8'd25;
  localparam logic [11:0] RST_WIDTH   = 12'd700;
  localparam logic [9:0]  RST_LAG     = 10'd60;

  localparam wide_t SPEED_MAX   = 48'sd1000;
  localparam wide_t SPEED_JUMP  = 48'sd50;
  localparam wide_t APPROACH_VY = -48'sd50;
  localparam logic signed [15:0] SPEED_SCALE = 16'sd100;
  localparam logic signed [15:0] TIME_SCALE  = 16'sd120;

  typedef enum logic [3:0] {
    OP_SPX, OP_SPY, OP_FILT, OP_BRANCH, OP_X, OP_ATT, OP_BY, OP_T,
    OP_X2, OP_BOUNCE, OP_T2, OP_DIRECT, OP_HIT, OP_REACH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_START, ST_DIV, ST_WB, ST_EVAL, ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_start;
    logic wb;
    logic eval;
    logic fin;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic noise;
    logic approach;
    logic x_out;
    logic x2_out;
    logic spy_jump;
    logic after_bounce;
    logic out_free;
  } stat_t;

  function automatic word_t sat16(wide_t v);
    if (v < -48'sd32768) return -16'sd32768;
    if (v > 48'sd32767) return 16'sd32767;
    return 16'(v);
  endfunction

  // speed smoothing: average when close to the last speed, then clamp
  function automatic speed_t filt(wide_t cur, wide_t prev);
    wide_t d;
    wide_t r;
    d = cur - prev;
    if (d < 0) d = -d;
    r = (d < SPEED_JUMP) ? ((cur + prev) >>> 1) : cur;
    if (r < -SPEED_MAX) r = -SPEED_MAX;
    else if (r > SPEED_MAX) r = SPEED_MAX;
    return 11'(r);
  endfunction

endpackage
`default_nettype wire

>>> hdl/ptp_div.sv
// ptp_div: signed restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on ptp_pkg. A zero divisor gives a zero quotient.
`default_nettype none
module ptp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire ptp_pkg::wide_t                    num,
  input  wire logic signed [ptp_pkg::DEN_W-1:0]  den,
  output ptp_pkg::wide_t                         quo,
  output logic                                   done
);
  import ptp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dabs;
  logic             neg;
  logic             dzero;

  logic [NUM_W-1:0] nabs_in;
  logic [DEN_W-1:0] dabs_in;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] nq_next;

  assign nabs_in  = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
  assign dabs_in  = (den < 0) ? DEN_W'(-den) : DEN_W'(den);
  assign rem_sh   = {rem, nq[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, dabs};
  assign rem_next = ge ? DEN_W'(rem_sh - {1'b0, dabs}) : rem_sh[DEN_W-1:0];
  assign nq_next  = {nq[NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        nq    <= nabs_in;
        rem   <= '0;
        dabs  <= dabs_in;
        neg   <= (num < 0) ^ (den < 0);
        dzero <= (den == 0);
      end else if (busy) begin
        nq  <= nq_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (dzero) quo <= '0;
          else if (neg) quo <= -wide_t'(nq_next);
          else quo <= wide_t'(nq_next);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ptp_ctrl.sv
// ptp_ctrl: sequencer that walks the per-item operation list.
// Depends on ptp_pkg; drives ptp_dpath through cmd_t and reads stat_t back.
`default_nettype none
module ptp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output ptp_pkg::cmd_t       cmd,
  input  wire ptp_pkg::stat_t stat
);
  import ptp_pkg::*;

  state_t state, state_next;
  op_t    op_q, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op_q  <= OP_SPX;
    end else begin
      state <= state_next;
      op_q  <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op_q;
    cmd        = '0;
    cmd.op     = op_q;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          op_next    = OP_SPX;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = ST_MUL;
        case (op_q)
          OP_SPX: op_next = OP_SPY;
          OP_SPY: begin
            op_next    = OP_FILT;
            state_next = ST_EVAL;
          end
          OP_X:   op_next = OP_ATT;
          OP_ATT: begin
            if (stat.x_out) op_next = OP_BY;
            else begin
              op_next    = OP_DIRECT;
              state_next = ST_EVAL;
            end
          end
          OP_BY:  op_next = OP_T;
          OP_T:   op_next = OP_X2;
          OP_X2: begin
            op_next    = OP_BOUNCE;
            state_next = ST_EVAL;
          end
          OP_HIT: op_next = OP_REACH;
          default: state_next = ST_FIN;
        endcase
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_FIN;
        case (op_q)
          OP_FILT: begin
            if (!stat.noise) begin
              op_next    = OP_BRANCH;
              state_next = ST_EVAL;
            end
          end
          OP_BRANCH: begin
            if (stat.approach) begin
              op_next    = OP_X;
              state_next = ST_MUL;
            end
          end
          OP_BOUNCE: begin
            if (!stat.x2_out && !stat.spy_jump) begin
              op_next    = OP_T2;
              state_next = ST_MUL;
            end
          end
          OP_DIRECT: begin
            if (!stat.after_bounce) begin
              op_next    = OP_HIT;
              state_next = ST_MUL;
            end
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ptp_dpath.sv
// ptp_dpath: configuration, tracking state, multiplier, divider and output register.
// Depends on ptp_pkg and ptp_div; commanded by ptp_ctrl.
`default_nettype none
module ptp_dpath #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ptp_pkg::cmd_t cmd,
  output ptp_pkg::stat_t     stat,
  input  wire logic [39:0]   s_tdata,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [11:0]   cfg_data,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [95:0]        m_tdata
);
  import ptp_pkg::*;

  // configuration
  logic [11:0] dly, aly, tw;
  logic [7:0]  rad;
  logic [9:0]  lag;

  // tracking state
  logic signed [POSITION_BITS-1:0] last_pos_x, last_pos_y;
  wide_t  last_speed_x, last_speed_y;
  speed_t avg_x, avg_y;
  logic [1:0] pred_status;
  word_t  pred_x, earlier, hit, reach;
  logic   bounce_mark, after_bounce;

  // per-item working registers
  wide_t cx, cy, vx, vy, spx, spy, x, attack, bx, by, t, x2, num;
  logic [9:0] dt;
  logic signed [DEN_W-1:0] den;

  wide_t quo;
  logic  div_done;

  wide_t cx_in, cy_in, lpx, lpy, ld, la, lo, hi, lagw, bx_v, xm, x2m;
  logic [9:0] dt_in;
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [DEN_W-1:0] den_v;
  wide_t prod;
  wide_t spy_d;

  assign cx_in = wide_t'(signed'(s_tdata[12:0]));
  assign cy_in = wide_t'(signed'(s_tdata[25:13]));
  assign dt_in = s_tdata[35:26];
  assign lpx   = wide_t'(last_pos_x);
  assign lpy   = wide_t'(last_pos_y);
  assign ld    = wide_t'(dly) + wide_t'(rad);
  assign la    = wide_t'(aly) + wide_t'(rad);
  assign lo    = wide_t'(rad);
  assign hi    = wide_t'(tw) - wide_t'(rad);
  assign lagw  = wide_t'(lag);
  assign bx_v  = (x < lo) ? lo : hi;
  assign xm    = (earlier > 0) ? ((wide_t'(earlier) + x) >>> 1) : x;
  assign x2m   = (earlier != -16'sd1) ? ((wide_t'(earlier) + x2) >>> 1) : x2;
  assign spy_d = spy - last_speed_y;

  always_comb begin
    mul_a = 32'(vx);
    mul_b = SPEED_SCALE;
    den_v = DEN_W'({1'b0, dt});
    case (cmd.op)
      OP_SPY: mul_a = 32'(vy);
      OP_X: begin
        mul_a = 32'(ld - cy); mul_b = 16'(vx); den_v = DEN_W'(vy);
      end
      OP_ATT: begin
        mul_a = 32'(la - cy); mul_b = 16'(vx); den_v = DEN_W'(vy);
      end
      OP_BY: begin
        mul_a = 32'(bx_v - cx); mul_b = 16'(vy); den_v = DEN_W'(vx);
      end
      OP_T: begin
        mul_a = 32'(by - cy); den_v = DEN_W'(spy);
      end
      OP_X2: begin
        mul_a = 32'(by - ld); mul_b = 16'(vx); den_v = DEN_W'(vy);
      end
      OP_T2: begin
        mul_a = 32'(ld - cy); mul_b = TIME_SCALE; den_v = DEN_W'(spy);
      end
      OP_HIT: begin
        mul_a = 32'(ld - cy); den_v = DEN_W'(spy);
      end
      OP_REACH: begin
        mul_a = 32'(la - cy); den_v = DEN_W'(spy);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  ptp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    stat.div_done     = div_done;
    stat.noise        = (spx < -SPEED_MAX) || (spx > SPEED_MAX) ||
                        (spy < -SPEED_MAX) || (spy > SPEED_MAX);
    stat.approach     = wide_t'(avg_y) < APPROACH_VY;
    stat.x_out        = (x < lo) || (x > hi);
    stat.x2_out       = (x2 < lo) || (x2 > hi);
    stat.spy_jump     = (spy_d > SPEED_JUMP) || (spy_d < -SPEED_JUMP);
    stat.after_bounce = after_bounce;
    stat.out_free     = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly <= RST_DEFENSE; aly <= RST_ATTACK; rad <= RST_RADIUS;
      tw  <= RST_WIDTH;   lag <= RST_LAG;
      last_pos_x <= '0; last_pos_y <= '0;
      last_speed_x <= '0; last_speed_y <= '0;
      avg_x <= '0; avg_y <= '0;
      pred_status <= STAT_NONE;
      pred_x <= '0; earlier <= '0; hit <= '0; reach <= '0;
      bounce_mark <= 1'b0; after_bounce <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFENSE: dly <= cfg_data;
          CFG_ATTACK:  aly <= cfg_data;
          CFG_RADIUS:  rad <= cfg_data[7:0];
          CFG_WIDTH:   tw  <= cfg_data;
          CFG_LAG:     lag <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        cx <= cx_in;
        cy <= cy_in;
        dt <= (dt_in == '0) ? 10'd1 : dt_in;
        vx <= cx_in - lpx;
        vy <= cy_in - lpy;
        last_pos_x <= POSITION_BITS'(cx_in);
        last_pos_y <= POSITION_BITS'(cy_in);
        attack <= -48'sd1;
      end

      if (cmd.mul_load) begin
        num <= prod;
        den <= den_v;
        if (cmd.op == OP_BY) bx <= bx_v;
      end

      if (cmd.wb) begin
        case (cmd.op)
          OP_SPX: spx <= quo;
          OP_SPY: spy <= quo;
          OP_X:   x   <= quo + cx;
          OP_ATT: begin
            attack      <= quo + cx;
            pred_status <= STAT_DIRECT;
          end
          OP_BY:    by    <= quo + cy;
          OP_T:     t     <= quo;
          OP_X2:    x2    <= quo + bx;
          OP_T2:    hit   <= sat16(t + quo - lagw);
          OP_HIT:   hit   <= sat16(quo - lagw);
          OP_REACH: reach <= sat16(quo - lagw);
          default: ;
        endcase
      end

      if (cmd.eval) begin
        case (cmd.op)
          OP_FILT: begin
            if (stat.noise) begin
              pred_status <= STAT_NOISE;
              earlier     <= -16'sd1;
            end else if (pred_status == STAT_NOISE) begin
              avg_x <= 11'(spx);
              avg_y <= 11'(spy);
            end else begin
              avg_x <= filt(spx, last_speed_x);
              avg_y <= filt(spy, last_speed_y);
            end
          end
          OP_BRANCH: begin
            if (!stat.approach) begin
              earlier      <= -16'sd1;
              pred_status  <= STAT_NONE;
              bounce_mark  <= 1'b0;
              after_bounce <= 1'b0;
            end
          end
          OP_BOUNCE: begin
            bounce_mark  <= 1'b1;
            after_bounce <= 1'b1;
            if (stat.x2_out) begin
              earlier     <= -16'sd1;
              pred_status <= STAT_NONE;
              pred_x      <= sat16(x2);
              hit         <= sat16(t);
            end else if (stat.spy_jump) begin
              earlier     <= -16'sd1;
              pred_status <= STAT_BOUNCE;
              pred_x      <= sat16(x2);
              hit         <= sat16(t);
            end else begin
              earlier     <= sat16(x2m);
              pred_status <= STAT_BOUNCE;
              pred_x      <= sat16(x2m);
            end
          end
          OP_DIRECT: begin
            if (after_bounce) begin
              after_bounce <= 1'b0;
              pred_x       <= sat16(x);
            end else begin
              earlier <= sat16(xm);
              pred_x  <= sat16(xm);
            end
          end
          default: ;
        endcase
      end

      if (cmd.fin) begin
        last_speed_x <= spx;
        last_speed_y <= spy;
        m_tdata  <= {7'd0, bounce_mark, avg_y, avg_x, reach, hit, sat16(attack),
                     pred_x, pred_status};
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/puck_trajectory_predictor.sv
// Puck trajectory predictor top level: ptp_ctrl sequencer plus ptp_dpath datapath.
// Each quotient on the shared 48-bit serial divider takes a load, a start, a wait and
// a write back; 2 to 8 quotients and the decision steps lie between the input
// transfer and the result being valid.
// One item at a time; the next item is taken while a result waits. Reset (rst,
// synchronous): clears tracking state, loads default configuration.
`default_nettype none
module puck_trajectory_predictor #(
  parameter int POSITION_BITS = 16   // width of the stored last position
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transfer
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // puck_x[12:0], puck_y[25:13], interval_ms[35:26]
  // result transfer
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // status[1:0], predicted_x[17:2], attack_x[33:18],
                                      // impact_time_ms[49:34], attack_time_ms[65:50],
                                      // mean_speed_x[76:66], mean_speed_y[87:77],
                                      // bounce_flag[88]
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import ptp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller walks speed, filter, crossing and timing steps; each
  // division step is multiply, divider start, wait, write back.
  ptp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath holds config, track state, the multiplier and the divider,
  // and the output register that parts the two sides.
  ptp_dpath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

>>> hdl/ptp_checker.sv
// ptp_checker: port-level assertions for puck_trajectory_predictor, bound to the top.
// Depends on ptp_pkg for status codes.
`default_nettype none
module ptp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata
);
  import ptp_pkg::*;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an accepted item blocks the input for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // noise results never carry an attack crossing
  a_noise: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STAT_NOISE) |-> m_tdata[33:18] == 16'hFFFF)
    else $error("noise result with attack crossing");

  // filtered speeds stay within the clamp
  a_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[76:66]) >= -11'sd1000) &&
                 ($signed(m_tdata[76:66]) <= 11'sd1000) &&
                 ($signed(m_tdata[87:77]) >= -11'sd1000) &&
                 ($signed(m_tdata[87:77]) <= 11'sd1000))
    else $error("filtered speed out of range");

endmodule

bind puck_trajectory_predictor ptp_checker u_ptp_checker (.*);
`default_nettype wire

>>> tb/sv/ptp_scoreboard.sv
// ptp_scoreboard: watches the input, result and configuration ports of the puck
// trajectory predictor, predicts every result and compares it field by field.
// Depends on ptp_pkg for status codes and register indexes.
`timescale 1ns / 1ps
module ptp_scoreboard
  import ptp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [95:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  output int               mismatches,
  output int               results_seen,
  output int               results_left
);

  typedef struct {
    logic [1:0]  status;
    logic [15:0] pred_x;
    logic [15:0] attack_x;
    logic [15:0] hit_ms;
    logic [15:0] reach_ms;
    logic [10:0] speed_x;
    logic [10:0] speed_y;
    logic        bounce;
  } track_t;

  track_t pending_tracks[$];

  // configuration copy
  longint line_def, line_att, radius, width, lag;
  // tracking state
  longint prev_x, prev_y, prev_spx, prev_spy, avg_x, avg_y;
  longint status_q, stored_x, older_x, bounce_q, bounced_q, hit_q, reach_q;

  function automatic longint qdiv(longint n, longint d);
    return (d == 0) ? 0 : n / d;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_word(longint v);
    return clip(v, -32768, 32767);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // smoothing: arithmetic shift gives the floor of the half
  function automatic longint smooth(longint cur, longint prev);
    longint r;
    r = (mag(cur - prev) < 50) ? ((cur + prev) >>> 1) : cur;
    return clip(r, -1000, 1000);
  endfunction

  task automatic predict_track(input logic [39:0] d, output track_t r);
    longint cx, cy, dt, vx, vy, spx, spy, psy, aim;
    longint ld, la, lo, hi, x, bx, by, t, x2;
    logic signed [15:0] pos;
    cx = longint'($signed(d[12:0]));
    cy = longint'($signed(d[25:13]));
    dt = (d[35:26] == 0) ? 1 : longint'(d[35:26]);
    aim = -1;
    vx = cx - prev_x;
    vy = cy - prev_y;
    pos = 16'(cx); prev_x = pos;
    pos = 16'(cy); prev_y = pos;
    psy = prev_spy;
    spx = (vx * 100) / dt;
    spy = (vy * 100) / dt;
    if (spx < -1000 || spx > 1000 || spy < -1000 || spy > 1000) begin
      status_q = STAT_NOISE;
      older_x = -1;
    end else begin
      if (status_q == STAT_NOISE) begin
        avg_x = spx;
        avg_y = spy;
      end else begin
        avg_x = smooth(spx, prev_spx);
        avg_y = smooth(spy, psy);
      end
      if (avg_y < -50) begin
        ld = line_def + radius;
        la = line_att + radius;
        lo = radius;
        hi = width - radius;
        x = qdiv((ld - cy) * vx, vy) + cx;
        status_q = STAT_DIRECT;
        aim = qdiv((la - cy) * vx, vy) + cx;
        if (x < lo || x > hi) begin
          // crossing lies beyond a side wall: mirror once
          bx = (x < lo) ? lo : hi;
          by = qdiv((bx - cx) * vy, vx) + cy;
          t = qdiv((by - cy) * 100, spy);
          x2 = qdiv(-(ld - by) * vx, vy) + bx;
          status_q = STAT_BOUNCE;
          bounce_q = 1;
          bounced_q = 1;
          stored_x = sat_word(x2);
          if (x2 < lo || x2 > hi) begin
            older_x = -1;
            status_q = STAT_NONE;
            hit_q = sat_word(t);
          end else if (mag(spy - psy) > 50) begin
            older_x = -1;
            hit_q = sat_word(t);
          end else begin
            if (older_x != -1) x2 = (older_x + x2) >>> 1;
            older_x = sat_word(x2);
            stored_x = sat_word(x2);
            t += qdiv((ld - cy) * 120, spy);
            t -= lag;
            hit_q = sat_word(t);
          end
        end else begin
          stored_x = sat_word(x);
          if (bounced_q == 1) begin
            bounced_q = 0;
          end else begin
            if (older_x > 0) x = (older_x + x) >>> 1;
            older_x = sat_word(x);
            stored_x = sat_word(x);
            hit_q = sat_word(qdiv((ld - cy) * 100, spy) - lag);
            reach_q = sat_word(qdiv((la - cy) * 100, spy) - lag);
          end
        end
      end else begin
        older_x = -1;
        status_q = STAT_NONE;
        bounce_q = 0;
        bounced_q = 0;
      end
    end
    prev_spx = spx;
    prev_spy = spy;
    r.status = 2'(status_q);
    r.pred_x = 16'(stored_x);
    r.attack_x = 16'(sat_word(aim));
    r.hit_ms = 16'(hit_q);
    r.reach_ms = 16'(reach_q);
    r.speed_x = 11'(avg_x);
    r.speed_y = 11'(avg_y);
    r.bounce = bounce_q[0];
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    track_t e;
    if (rst) begin
      line_def = RST_DEFENSE; line_att = RST_ATTACK; radius = RST_RADIUS;
      width = RST_WIDTH; lag = RST_LAG;
      prev_x = 0; prev_y = 0; prev_spx = 0; prev_spy = 0; avg_x = 0; avg_y = 0;
      status_q = STAT_NONE; stored_x = 0; older_x = 0; bounce_q = 0; bounced_q = 0;
      hit_q = 0; reach_q = 0;
      mismatches = 0;
      results_seen = 0;
      pending_tracks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFENSE: line_def = cfg_data;
          CFG_ATTACK:  line_att = cfg_data;
          CFG_RADIUS:  radius = cfg_data[7:0];
          CFG_WIDTH:   width = cfg_data;
          CFG_LAG:     lag = cfg_data[9:0];
          default: ;
        endcase
      end
      // result side first: it always belongs to an earlier transfer
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_tracks.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          e = pending_tracks.pop_front();
          check_field("status", e.status, m_tdata[1:0]);
          check_field("predicted_x", $signed(e.pred_x), $signed(m_tdata[17:2]));
          check_field("attack_x", $signed(e.attack_x), $signed(m_tdata[33:18]));
          check_field("impact_time_ms", $signed(e.hit_ms), $signed(m_tdata[49:34]));
          check_field("attack_time_ms", $signed(e.reach_ms), $signed(m_tdata[65:50]));
          check_field("mean_speed_x", $signed(e.speed_x), $signed(m_tdata[76:66]));
          check_field("mean_speed_y", $signed(e.speed_y), $signed(m_tdata[87:77]));
          check_field("bounce_flag", e.bounce, m_tdata[88]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_track(s_tdata, e);
        pending_tracks.push_back(e);
      end
    end
    results_left = pending_tracks.size();
  end

endmodule

>>> tb/sv/tb_puck_trajectory_predictor.sv
// tb_puck_trajectory_predictor: stimulus and verdict for the puck trajectory predictor.
// Drives directed and trajectory-shaped random readings across register settings;
// checking lives in ptp_scoreboard. Depends on ptp_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_puck_trajectory_predictor;
  import ptp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // puck_x[12:0], puck_y[25:13], interval_ms[35:26]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // status, predicted_x, attack_x, impact_time_ms,
                               // attack_time_ms, mean_speed_x, mean_speed_y, bounce_flag
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DEFENSE;
  logic [11:0] cfg_data = '0;

  int mismatches, results_seen, results_left;
  int sent = 0;
  int cycles = 0;
  int setups = 0;
  bit steady = 0;        // no idling on either side
  int hold_ask = 0;      // bumped to request a long receiver hold-off
  int hold_seen = 0;
  int hold_left = 0;

  // table geometry in use, for shaping trajectories
  int cur_width = 700;
  int cur_radius = 25;

  always #6 clk = ~clk;

  puck_trajectory_predictor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ptp_scoreboard scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .results_seen(results_seen), .results_left(results_left)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** puck_trajectory_predictor: FAILED **");
      $finish;
    end
  end

  // result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 18);
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // one reading: offered until the transfer, then maybe a gap
  task automatic send_reading(input int x, input int y, input int dt);
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, 10'(dt), 13'(y), 13'(x)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (!steady && chance(18)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every prediction has been checked
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setup(input int ld, input int la, input int rad, input int w,
                            input int lag);
    int vals[5];
    vals = '{ld, la, rad, w, lag};
    foreach (vals[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 12'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_radius = rad;
    cur_width = w;
    setups++;
  endtask

  function automatic int clip_pos(int v);
    return (v < -2048) ? -2048 : ((v > 4095) ? 4095 : v);
  endfunction

  // puck runs toward the robot with steady speed and small jitter, bouncing
  // off the side walls; a share of readings are noise or broken tracks
  task automatic random_tracks(input int count);
    int x, y, vx, vy, dt, steps, n, span;
    n = 0;
    while (n < count) begin
      span = (cur_width > 0) ? cur_width : 1;
      x = $urandom_range(0, span);
      y = $urandom_range(300, 3000);
      vx = int'($urandom_range(0, 1200)) - 600;
      vy = -int'($urandom_range(40, 950));
      steps = $urandom_range(3, 20);
      while (steps > 0 && n < count) begin
        if (chance(12)) begin
          send_reading($urandom_range(0, 6143) - 2048, $urandom_range(0, 6143) - 2048,
                       $urandom_range(0, 1023));
        end else begin
          dt = chance(10) ? $urandom_range(1, 1023) : $urandom_range(4, 60);
          x += (vx * dt) / 100 + int'($urandom_range(0, 4)) - 2;
          y += (vy * dt) / 100 + int'($urandom_range(0, 4)) - 2;
          if (x < 0) begin
            x = -x; vx = -vx;
          end else if (x > span) begin
            x = 2 * span - x; vx = -vx;
          end
          if (chance(5)) vy = -vy;
          x = clip_pos(x);
          y = clip_pos(y);
          send_reading(x, y, dt);
        end
        n++;
        steps--;
        if (y < -300) steps = 0;
      end
    end
  endtask

  task automatic directed_readings;
    // field extremes, zero interval, and noise in both directions
    send_reading(-2048, -2048, 1);
    send_reading(4095, 4095, 1023);
    send_reading(4095, -2048, 0);
    send_reading(0, 0, 1023);
    send_reading(0, 0, 0);
    // straight approach with no x movement
    send_reading(300, 1500, 20);
    send_reading(300, 1400, 100);
    send_reading(300, 1300, 100);
    send_reading(300, 1200, 100);
    // approach ending past the right wall, then onto the line
    send_reading(500, 1500, 50);
    send_reading(560, 1400, 50);
    send_reading(620, 1300, 50);
    send_reading(680, 1200, 50);
    send_reading(640, 1100, 50);
    send_reading(600, 1000, 50);
    // shallow diagonal, mostly sideways
    send_reading(50, 2000, 50);
    send_reading(0, 1990, 50);
    // moving away, then a sudden jump
    send_reading(200, 300, 50);
    send_reading(210, 400, 50);
    send_reading(3000, 100, 10);
    send_reading(3001, 99, 10);
    // speed exactly at the limit
    send_reading(3001, -1, 10);
    send_reading(2901, -1, 10);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults
    directed_readings();
    random_tracks(110);
    drain();

    // low extremes: zero lines and margin, one-mm table
    load_setup(0, 0, 0, 1, 0);
    directed_readings();
    random_tracks(60);
    drain();

    // high extremes
    load_setup(4095, 4095, 255, 4095, 1023);
    directed_readings();
    random_tracks(80);

    // long receiver hold-off while items keep coming
    hold_ask++;
    random_tracks(40);
    drain();

    // table narrower than twice the margin
    load_setup(150, 400, 40, 60, 30);
    random_tracks(80);
    drain();

    // typical geometry, no idling
    load_setup(100, 200, 25, 700, 60);
    steady = 1;
    random_tracks(150);
    steady = 0;
    drain();

    load_setup(300, 900, 30, 900, 100);
    random_tracks(180);
    drain();

    repeat (500) @(posedge clk);
    $display("Run covered %0d readings over %0d register setups, %0d results checked.",
             sent, setups, results_seen);
    $display("Included noise, bounces, zero movement, long back-pressure and extremes.");
    if (mismatches == 0 && results_left == 0 && results_seen == sent) begin
      $display("** puck_trajectory_predictor: PASSED **");
    end else begin
      $display("** puck_trajectory_predictor: FAILED **");
    end
    $finish;
  end

endmodule
